// ===== rtl/core/rft_pkg.sv =====
// rft_pkg: shared constants, controller state codes and the command/status
// structs between the rail fence controller and datapath.
// No dependencies; every other file of the block refers to it by scoped names.
package rft_pkg;

	// buffer geometry
	localparam int MAX_LEN = 64;
	localparam int ADDR_W  = $clog2(MAX_LEN);
	localparam int CNT_W   = ADDR_W + 1;

	// field widths
	localparam int CHAR_W = 8;
	localparam int ROWS_W = 7;
	// zigzag position and period: 2*rows-2 for 7-bit rows fits in 8 bits
	localparam int POS_W  = ROWS_W + 1;

	// register value after reset
	localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(1);

	// controller states, one-hot
	typedef enum logic [2:0] {
		ST_LOAD = 3'b001,
		ST_PREP = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;   // store the character of an input transfer
		logic prep;   // latch mode and period, rewind the sequencer
		logic issue;  // read one buffer entry into the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;  // output register can take a new result this cycle
		logic final_pos; // the sequencer points at the last result of the string
	} sts_t;

endpackage

// ===== rtl/core/rft_text_if.sv =====
// rft_text_if: valid/ready channel carrying input characters and last flag.
// Depends on rft_pkg for the character width.
interface rft_text_if;
	logic                      valid;
	logic                      ready;
	logic [rft_pkg::CHAR_W-1:0] in_char;
	logic                      in_last;

	modport source (output valid, output in_char, output in_last, input ready);
	modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

// ===== rtl/core/rft_cipher_if.sv =====
// rft_cipher_if: valid/ready channel carrying transposed characters with
// last and overflow flags. Depends on rft_pkg for the character width.
interface rft_cipher_if;
	logic                      valid;
	logic                      ready;
	logic [rft_pkg::CHAR_W-1:0] out_char;
	logic                      out_last;
	logic                      overflow;

	modport source (output valid, output out_char, output out_last, output overflow,
		input ready);
	modport sink   (input valid, input out_char, input out_last, input overflow,
		output ready);
endinterface

// ===== rtl/core/rft_ctrl.sv =====
// rft_ctrl: controller state machine of the rail fence transposer.
// Depends on rft_pkg (state_t, cmd_t, sts_t).
module rft_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_last,
	output logic           in_ready,
	input  rft_pkg::sts_t  sts,
	output rft_pkg::cmd_t  cmd
);

	rft_pkg::state_t state_q;
	rft_pkg::state_t state_d;
	logic            in_xfer;

	// input handshake only while loading
	assign in_ready = (state_q == rft_pkg::ST_LOAD);
	assign in_xfer  = in_valid && in_ready;

	// commands
	always_comb begin
		cmd       = '0;
		cmd.load  = in_xfer;
		cmd.prep  = (state_q == rft_pkg::ST_PREP);
		cmd.issue = (state_q == rft_pkg::ST_EMIT) && sts.out_free;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rft_pkg::ST_LOAD: begin
				if (in_xfer && in_last)
					state_d = rft_pkg::ST_PREP;
			end
			rft_pkg::ST_PREP: begin
				state_d = rft_pkg::ST_EMIT;
			end
			rft_pkg::ST_EMIT: begin
				if (sts.out_free && sts.final_pos)
					state_d = rft_pkg::ST_LOAD;
			end
			default: begin
				state_d = rft_pkg::ST_LOAD;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= rft_pkg::ST_LOAD;
		else
			state_q <= state_d;
	end

endmodule

// ===== rtl/core/rft_datapath.sv =====
// rft_datapath: character buffer, fill count, zigzag address sequencer,
// rail count register and output register of the rail fence transposer.
// Depends on rft_pkg (geometry constants, cmd_t, sts_t).
module rft_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         num_rows_we,
	input  logic [rft_pkg::ROWS_W-1:0]   num_rows,
	input  logic [rft_pkg::CHAR_W-1:0]   in_char,
	input  rft_pkg::cmd_t                cmd,
	output rft_pkg::sts_t                sts,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [rft_pkg::CHAR_W-1:0]   out_char,
	output logic                         out_last,
	output logic                         overflow
);

	logic [rft_pkg::CHAR_W-1:0] mem [rft_pkg::MAX_LEN];

	logic [rft_pkg::ROWS_W-1:0] rows_q;
	logic [rft_pkg::CNT_W-1:0]  count_q;
	logic                       ovf_q;

	logic                       direct_q;
	logic [rft_pkg::POS_W-1:0]  period_q;
	logic [rft_pkg::POS_W-1:0]  pos_q;
	logic [rft_pkg::ROWS_W-1:0] rail_q;
	logic                       phase_q;
	logic [rft_pkg::CNT_W-1:0]  emit_cnt_q;

	logic                       out_valid_q;
	logic [rft_pkg::CHAR_W-1:0] out_char_q;
	logic                       out_last_q;
	logic                       out_ovf_q;

	logic                       buf_full;
	logic                       final_pos;
	logic                       edge_rail;
	logic [rft_pkg::POS_W-1:0]  twice_rail;
	logic [rft_pkg::POS_W-1:0]  step;
	logic [rft_pkg::POS_W:0]    pos_sum;
	logic                       rail_end;
	logic [rft_pkg::ROWS_W-1:0] rail_nxt;

	assign buf_full  = (count_q == rft_pkg::CNT_W'(rft_pkg::MAX_LEN));
	assign final_pos = (emit_cnt_q == (count_q - rft_pkg::CNT_W'(1)));

	// zigzag step: edge rails jump a full period, middle rails alternate
	assign edge_rail  = (rail_q == '0) || (rail_q == (rows_q - rft_pkg::ROWS_W'(1)));
	assign twice_rail = {rail_q, 1'b0};
	always_comb begin
		if (edge_rail)
			step = period_q;
		else if (phase_q)
			step = twice_rail;
		else
			step = period_q - twice_rail;
	end
	assign pos_sum  = {1'b0, pos_q} + {1'b0, step};
	assign rail_end = (pos_sum >= (rft_pkg::POS_W+1)'(count_q));
	assign rail_nxt = rail_q + rft_pkg::ROWS_W'(1);

	// status to controller
	always_comb begin
		sts           = '0;
		sts.out_free  = !out_valid_q || out_ready;
		sts.final_pos = final_pos;
	end

	// rail count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rows_q <= rft_pkg::ROWS_RESET;
		else if (num_rows_we)
			rows_q <= num_rows;
	end

	// fill count and overflow mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.issue && final_pos) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.load) begin
			if (buf_full)
				ovf_q <= 1'b1;
			else
				count_q <= count_q + rft_pkg::CNT_W'(1);
		end
	end

	// buffer write and registered read into the output character
	always_ff @(posedge clk) begin
		if (cmd.load && !buf_full)
			mem[count_q[rft_pkg::ADDR_W-1:0]] <= in_char;
		if (cmd.issue)
			out_char_q <= mem[pos_q[rft_pkg::ADDR_W-1:0]];
	end

	// address sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direct_q   <= 1'b1;
			period_q   <= '0;
			pos_q      <= '0;
			rail_q     <= '0;
			phase_q    <= 1'b0;
			emit_cnt_q <= '0;
		end else if (cmd.prep) begin
			direct_q   <= (rows_q <= rft_pkg::ROWS_W'(1)) ||
				((rft_pkg::POS_W)'(rows_q) >= (rft_pkg::POS_W)'(count_q));
			period_q   <= {rows_q, 1'b0} - rft_pkg::POS_W'(2);
			pos_q      <= '0;
			rail_q     <= '0;
			phase_q    <= 1'b0;
			emit_cnt_q <= '0;
		end else if (cmd.issue) begin
			emit_cnt_q <= emit_cnt_q + rft_pkg::CNT_W'(1);
			if (direct_q) begin
				pos_q <= pos_q + rft_pkg::POS_W'(1);
			end else if (rail_end) begin
				rail_q  <= rail_nxt;
				pos_q   <= rft_pkg::POS_W'(rail_nxt);
				phase_q <= 1'b0;
			end else begin
				pos_q   <= pos_sum[rft_pkg::POS_W-1:0];
				phase_q <= !phase_q;
			end
		end
	end

	// output register flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else if (cmd.issue) begin
			out_valid_q <= 1'b1;
			out_last_q  <= final_pos;
			out_ovf_q   <= ovf_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;
	assign overflow  = out_ovf_q;

endmodule

// ===== rtl/core/rail_fence_transposer_unit.sv =====
// rail_fence_transposer_unit: top level, joins controller and datapath.
// Depends on rft_pkg, rft_text_if, rft_cipher_if, rft_ctrl, rft_datapath.
//
//   channel   | direction | payload                       | transfer when
//   ----------+-----------+-------------------------------+--------------------
//   text      | in        | in_char[7:0], in_last         | valid && ready
//   cipher    | out       | out_char[7:0], out_last,      | valid && ready
//             |           | overflow                      |
//   num_rows  | in        | num_rows[6:0]                 | num_rows_we high
//
// Loading takes one character per cycle. After the last character, the PREP
// state sets up the zigzag sequencer; then one result leaves per cycle while
// the output is free, paced by the single read port of the character buffer.
// Input is held off (ready low) from the last character until the final
// result is loaded into the output register; a stalled output simply pauses
// the sequencer.
// Reset clears the fill count and flags; the buffer needs no clearing pass.
module rail_fence_transposer_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	rft_text_if.sink                   text,
	rft_cipher_if.source               cipher,
	input  logic                       num_rows_we,
	input  logic [rft_pkg::ROWS_W-1:0] num_rows
);

	rft_pkg::cmd_t cmd;
	rft_pkg::sts_t sts;

	// controller
	rft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (text.valid),
		.in_last  (text.in_last),
		.in_ready (text.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	rft_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.num_rows_we (num_rows_we),
		.num_rows    (num_rows),
		.in_char     (text.in_char),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (cipher.valid),
		.out_ready   (cipher.ready),
		.out_char    (cipher.out_char),
		.out_last    (cipher.out_last),
		.overflow    (cipher.overflow)
	);

endmodule

// ===== dv/rail_fence_transposer_unit_tb.sv =====
`timescale 1ns / 100ps
// rail_fence_transposer_unit_tb: self-checking bench for the rail fence transposer.
// Directed and random strings are sent over several rail counts. A scoreboard predicts each
// cipher transfer. Depends on rft_pkg, rft_text_if, rft_cipher_if and the top level.

typedef struct packed {
	logic [rft_pkg::CHAR_W-1:0] ch;
	logic                       last;
	logic                       ovf;
} cipher_beat_t;

// predicts the zigzag order of each string and checks the cipher transfers against it
class zigzag_scoreboard;
	logic [rft_pkg::CHAR_W-1:0] held_chars [rft_pkg::MAX_LEN];
	int unsigned                fill;
	bit                         dropped;
	int unsigned                rail_count;
	cipher_beat_t               expected_q [$];
	int unsigned                mismatches;

	function new();
		fill       = 0;
		dropped    = 1'b0;
		rail_count = rft_pkg::ROWS_RESET;
		mismatches = 0;
	endfunction

	function void set_rails(int unsigned v);
		rail_count = v;
	endfunction

	// rail that a string position lands on, for two or more rails
	function int unsigned rail_of_pos(int unsigned pos, int unsigned rails);
		int unsigned period;
		int unsigned m;
		period = 2 * rails - 2;
		m = pos % period;
		return (m < rails) ? m : (period - m);
	endfunction

	function void push_char(int unsigned pos);
		cipher_beat_t beat;
		beat.ch   = held_chars[pos];
		beat.last = 1'b0;
		beat.ovf  = dropped;
		expected_q.insert(expected_q.size(), beat);
	endfunction

	// accepted text transfer: store or drop, and on the last one queue the whole string
	function void note_char(logic [rft_pkg::CHAR_W-1:0] ch, logic last);
		cipher_beat_t beat;
		int unsigned  n;
		if (fill < rft_pkg::MAX_LEN) begin
			held_chars[fill] = ch;
			fill++;
		end else begin
			dropped = 1'b1;
		end
		if (!last)
			return;
		n = fill;
		if (rail_count <= 1 || rail_count >= n) begin
			for (int unsigned i = 0; i < n; i++)
				push_char(i);
		end else begin
			for (int unsigned r = 0; r < rail_count; r++)
				for (int unsigned i = 0; i < n; i++)
					if (rail_of_pos(i, rail_count) == r)
						push_char(i);
		end
		// final character of the string carries the last flag
		beat = expected_q[expected_q.size() - 1];
		beat.last = 1'b1;
		expected_q[expected_q.size() - 1] = beat;
		fill    = 0;
		dropped = 1'b0;
	endfunction

	// accepted cipher transfer against the oldest expectation
	function void check_beat(logic [rft_pkg::CHAR_W-1:0] ch, logic last, logic ovf);
		cipher_beat_t want;
		if (expected_q.size() == 0) begin
			mismatches++;
			$display("%0t: unexpected cipher transfer, expected none, actual char %02h last %0b overflow %0b",
				$time, ch, last, ovf);
			return;
		end
		want = expected_q.pop_front();
		if (ch !== want.ch) begin
			mismatches++;
			$display("%0t: out_char mismatch, expected %02h, actual %02h", $time, want.ch, ch);
		end
		if (last !== want.last) begin
			mismatches++;
			$display("%0t: out_last mismatch, expected %0b, actual %0b", $time, want.last, last);
		end
		if (ovf !== want.ovf) begin
			mismatches++;
			$display("%0t: overflow mismatch, expected %0b, actual %0b", $time, want.ovf, ovf);
		end
	endfunction
endclass

module rail_fence_transposer_unit_tb;

	localparam int HALF_PERIOD = 2;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       rows_we;
	logic [rft_pkg::ROWS_W-1:0] rows_val;
	bit                         no_gaps;
	int unsigned                beats_seen = 0;

	zigzag_scoreboard board = new();

	rft_text_if   text_ch ();
	rft_cipher_if cipher_ch ();

	rail_fence_transposer_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.text        (text_ch),
		.cipher      (cipher_ch),
		.num_rows_we (rows_we),
		.num_rows    (rows_val)
	);

	// clock
	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	// random idle cycle, off during the gap-free stretch
	function automatic bit gap_now();
		return !no_gaps && ($urandom_range(0, 99) < 26);
	endfunction

	// string length: mostly short, some long up to the buffer depth
	function automatic int unsigned pick_len();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 70)
			return $urandom_range(1, 8);
		else if (sel < 90)
			return $urandom_range(9, 24);
		return $urandom_range(25, rft_pkg::MAX_LEN);
	endfunction

	// one text transfer, with random idle cycles ahead of it
	task automatic send_char(input logic [rft_pkg::CHAR_W-1:0] ch, input logic last);
		while (gap_now()) begin
			text_ch.valid <= 1'b0;
			@(posedge clk);
		end
		text_ch.valid   <= 1'b1;
		text_ch.in_char <= ch;
		text_ch.in_last <= last;
		@(posedge clk);
		while (!text_ch.ready)
			@(posedge clk);
		board.note_char(ch, last);
	endtask

	// register write, only while the block is idle
	task automatic write_rails(input logic [rft_pkg::ROWS_W-1:0] v);
		rows_we  <= 1'b1;
		rows_val <= v;
		@(posedge clk);
		rows_we <= 1'b0;
		board.set_rails(v);
	endtask

	// wait until every expected transfer has arrived, then let the block settle
	task automatic drain();
		while (board.expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// cipher sink: checks transfers, random stalls and one long hold-off
	initial begin : cipher_sink
		int unsigned hold_left;
		bit          hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		cipher_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (cipher_ch.valid && cipher_ch.ready) begin
				board.check_beat(cipher_ch.out_char, cipher_ch.out_last, cipher_ch.overflow);
				beats_seen++;
			end
			// hold off while the sender keeps offering, so the input stalls
			if (!hold_done && beats_seen > 40 && cipher_ch.valid && text_ch.valid) begin
				hold_done = 1'b1;
				hold_left = 200;
			end
			if (hold_left != 0) begin
				hold_left--;
				cipher_ch.ready <= 1'b0;
			end else begin
				cipher_ch.ready <= !gap_now();
			end
		end
	end

	// stimulus
	initial begin : text_source
		int unsigned                dir_rows [7] = '{1, 0, 2, 2, 3, 127, 64};
		int unsigned                dir_lens [7] = '{3, 2, 1, 5, 7, 4, 3};
		logic [rft_pkg::CHAR_W-1:0] dir_chars [25] = '{
			8'h00, 8'hFF, 8'h5A,
			8'h01, 8'h80,
			8'hFF,
			8'h10, 8'h11, 8'h12, 8'h13, 8'h14,
			8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
			8'hA5, 8'h7F, 8'hC3, 8'h3C,
			8'hFE, 8'h00, 8'h55};
		int unsigned                phase_rows [10] = '{2, 3, 5, 63, 64, 65, 127, 0, 4, 1};
		int unsigned                pos;
		int unsigned                sent;
		int unsigned                len;

		text_ch.valid   = 1'b0;
		text_ch.in_char = '0;
		text_ch.in_last = 1'b0;
		rows_we         = 1'b0;
		rows_val        = '0;
		no_gaps         = 1'b0;
		arst_n          = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed strings: reset rail count first, then zero, few and many rails
		pos = 0;
		for (int k = 0; k < 7; k++) begin
			if (k > 0) begin
				drain();
				write_rails(rft_pkg::ROWS_W'(dir_rows[k]));
			end
			for (int i = 0; i < dir_lens[k]; i++) begin
				send_char(dir_chars[pos], i == dir_lens[k] - 1);
				pos++;
			end
			text_ch.valid <= 1'b0;
		end

		// random strings, one rail count per phase
		for (int ph = 0; ph < 12; ph++) begin
			drain();
			write_rails(rft_pkg::ROWS_W'((ph < 10) ? phase_rows[ph] : $urandom_range(0, 127)));
			no_gaps = (ph == 6);
			sent = 0;
			while (sent < 6) begin
				// one phase opens with a string that overruns the buffer
				if ((ph == 2 && sent == 0) || $urandom_range(0, 39) == 0)
					len = rft_pkg::MAX_LEN + $urandom_range(1, 3);
				else
					len = pick_len();
				for (int i = 0; i < len; i++)
					send_char(rft_pkg::CHAR_W'($urandom_range(0, 255)), i == len - 1);
				sent += len;
			end
			text_ch.valid <= 1'b0;
		end
		no_gaps = 1'b0;

		// wait for the tail, bounded
		for (int c = 0; c < 50000 && board.expected_q.size() != 0; c++)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (board.mismatches == 0 && board.expected_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/rft_pkg.sv
rtl/core/rft_text_if.sv
rtl/core/rft_cipher_if.sv
rtl/core/rft_ctrl.sv
rtl/core/rft_datapath.sv
rtl/core/rail_fence_transposer_unit.sv
dv/rail_fence_transposer_unit_tb.sv
